/* rtl/core/mhpq_pkg.sv */
// Package for the max-heap priority queue core.
// Holds operation and status codes, field types and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_POP    = 2'd1;
    localparam t_op OP_REMOVE = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam int DEF_CAPACITY     = 64;
    localparam int DEF_KEY_BITS     = 16;
    localparam int DEF_URGENCY_BITS = 16;

endpackage

`default_nettype wire

/* rtl/core/max_heap_priority_queue_core.sv */
// Max-heap priority queue core: sequencer over one RAM and one shared comparator.
// Insert climbs from the new last slot; pop moves the last entry to the root and
// sifts it down; remove scans all entries for the key, then sifts the moved entry.
// A new word is taken only once the previous result is loaded for output, and the
// RAM's single read port sets the pace.
// Sync active-low reset empties the heap, not the stores; uses mhpq_pkg/ram/cmp.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue_core #(
    parameter int CAPACITY     = mhpq_pkg::DEF_CAPACITY,
    parameter int KEY_BITS     = mhpq_pkg::DEF_KEY_BITS,
    parameter int URGENCY_BITS = mhpq_pkg::DEF_URGENCY_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire mhpq_pkg::t_op                       i_op,
    input  wire logic [KEY_BITS-1:0]                 i_key,
    input  wire logic signed [URGENCY_BITS-1:0]      i_urgency,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output mhpq_pkg::t_status                        o_status,
    output logic [KEY_BITS-1:0]                      o_out_key,
    output logic signed [URGENCY_BITS-1:0]           o_out_urgency,
    output logic [$clog2(CAPACITY+1)-1:0]            o_entry_count
);

    import mhpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 1;
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = KEY_BITS + URGENCY_BITS;
    localparam logic [CW-1:0] CAP_N = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_N = CW'(1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_POP_ROOT = 4'd1;
    localparam logic [3:0] S_POP_LAST = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_DN_RD_L  = 4'd4;
    localparam logic [3:0] S_DN_RD_R  = 4'd5;
    localparam logic [3:0] S_DN_SEL   = 4'd6;
    localparam logic [3:0] S_DN_CMP   = 4'd7;
    localparam logic [3:0] S_UP_RD    = 4'd8;
    localparam logic [3:0] S_UP_CMP   = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]                     r_state, n_state;
    logic [CW-1:0]                  r_n, n_n;
    logic [CW-1:0]                  r_p, n_p;
    logic [CW-1:0]                  r_c, n_c;
    logic [CW-1:0]                  r_scan, n_scan;
    logic [CW-1:0]                  r_found, n_found;
    logic                           r_moved, n_moved;
    logic [EW-1:0]                  r_v, n_v;
    logic [EW-1:0]                  r_ck, n_ck;
    logic [KEY_BITS-1:0]            r_qkey, n_qkey;
    t_status                        r_res_status, n_res_status;
    logic [KEY_BITS-1:0]            r_res_key, n_res_key;
    logic [URGENCY_BITS-1:0]        r_res_urg, n_res_urg;
    logic                           r_o_valid;
    t_status                        r_o_status;
    logic [KEY_BITS-1:0]            r_o_key;
    logic [URGENCY_BITS-1:0]        r_o_urg;
    logic [CW-1:0]                  r_o_count;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [EW-1:0]                  ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [EW-1:0]                  ram_rdata;
    logic [URGENCY_BITS-1:0]        cmp_a, cmp_b;
    logic                           cmp_gt;

    logic                           in_acc;
    logic                           out_load;
    logic                           hit;
    logic [CW-1:0]                  found_nx;
    logic [CW-1:0]                  p_m1, par, par_m1, n_m1;
    logic [PW-1:0]                  pos_l, pos_r, pos_l_m1, n_ext;
    logic [AW-1:0]                  addr_p;

    mhpq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mhpq_cmp #(
        .WIDTH (URGENCY_BITS)
    ) u_cmp (
        .i_a  ($signed(cmp_a)),
        .i_b  ($signed(cmp_b)),
        .o_gt (cmp_gt)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_load = (r_state == S_DONE) && (!r_o_valid || !i_stall);

    assign p_m1     = r_p - ONE_N;
    assign par      = r_p >> 1;
    assign par_m1   = par - ONE_N;
    assign n_m1     = r_n - ONE_N;
    assign pos_l    = {r_p, 1'b0};
    assign pos_r    = {r_p, 1'b1};
    assign pos_l_m1 = {p_m1, 1'b1};
    assign n_ext    = {1'b0, r_n};
    assign addr_p   = p_m1[AW-1:0];
    assign hit      = (ram_rdata[EW-1:URGENCY_BITS] == r_qkey);
    assign found_nx = hit ? r_scan : r_found;

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_p          = r_p;
        n_c          = r_c;
        n_scan       = r_scan;
        n_found      = r_found;
        n_moved      = r_moved;
        n_v          = r_v;
        n_ck         = r_ck;
        n_qkey       = r_qkey;
        n_res_status = r_res_status;
        n_res_key    = r_res_key;
        n_res_urg    = r_res_urg;
        ram_we       = 1'b0;
        ram_waddr    = addr_p;
        ram_wdata    = r_v;
        ram_raddr    = '0;
        cmp_a        = r_ck[URGENCY_BITS-1:0];
        cmp_b        = r_v[URGENCY_BITS-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_status = ST_OK;
                    n_res_key    = '0;
                    n_res_urg    = '0;
                    n_qkey       = i_key;
                    n_moved      = 1'b0;
                    case (i_op)
                        OP_INSERT: begin
                            if (r_n == CAP_N) begin
                                n_res_status = ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_n     = r_n + ONE_N;
                                n_p     = r_n + ONE_N;
                                n_v     = {i_key, i_urgency};
                                n_state = S_UP_RD;
                            end
                        end
                        OP_POP: begin
                            if (r_n == '0) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_POP_ROOT;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_n == '0) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_scan  = ONE_N;
                                n_found = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_POP_ROOT: begin
                n_res_key = ram_rdata[EW-1:URGENCY_BITS];
                n_res_urg = ram_rdata[URGENCY_BITS-1:0];
                ram_raddr = n_m1[AW-1:0];
                n_state   = S_POP_LAST;
            end
            S_POP_LAST: begin
                n_v     = ram_rdata;
                n_p     = ONE_N;
                n_n     = n_m1;
                n_state = (r_n == ONE_N) ? S_DONE : S_DN_RD_L;
            end
            S_SCAN: begin
                ram_raddr = r_scan[AW-1:0];
                n_scan    = r_scan + ONE_N;
                n_found   = found_nx;
                if (hit) begin
                    n_res_key = ram_rdata[EW-1:URGENCY_BITS];
                    n_res_urg = ram_rdata[URGENCY_BITS-1:0];
                end
                if (r_scan == r_n) begin
                    if (found_nx == '0) begin
                        n_res_status = ST_EMPTY;
                        n_state      = S_DONE;
                    end else begin
                        n_v     = ram_rdata;
                        n_p     = found_nx;
                        n_n     = n_m1;
                        n_state = (found_nx == r_n) ? S_DONE : S_DN_RD_L;
                    end
                end
            end
            S_DN_RD_L: begin
                if (pos_l > n_ext) begin
                    if (r_moved) begin
                        ram_we  = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_UP_RD;
                    end
                end else begin
                    ram_raddr = pos_l_m1[AW-1:0];
                    n_state   = S_DN_RD_R;
                end
            end
            S_DN_RD_R: begin
                n_ck = ram_rdata;
                n_c  = pos_l[CW-1:0];
                if (pos_r <= n_ext) begin
                    ram_raddr = pos_l[AW-1:0];
                    n_state   = S_DN_SEL;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_SEL: begin
                cmp_b = ram_rdata[URGENCY_BITS-1:0];
                if (!cmp_gt) begin
                    n_ck = ram_rdata;
                    n_c  = pos_r[CW-1:0];
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (cmp_gt) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_ck;
                    n_p       = r_c;
                    n_moved   = 1'b1;
                    n_state   = S_DN_RD_L;
                end else if (r_moved) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UP_RD;
                end
            end
            S_UP_RD: begin
                if (r_p == ONE_N) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = par_m1[AW-1:0];
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                cmp_a = r_v[URGENCY_BITS-1:0];
                cmp_b = ram_rdata[URGENCY_BITS-1:0];
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata = ram_rdata;
                    n_p       = par;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_n       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p          <= n_p;
        r_c          <= n_c;
        r_scan       <= n_scan;
        r_found      <= n_found;
        r_moved      <= n_moved;
        r_v          <= n_v;
        r_ck         <= n_ck;
        r_qkey       <= n_qkey;
        r_res_status <= n_res_status;
        r_res_key    <= n_res_key;
        r_res_urg    <= n_res_urg;
        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_key    <= r_res_key;
            r_o_urg    <= r_res_urg;
            r_o_count  <= r_n;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_out_key     = r_o_key;
    assign o_out_urgency = $signed(r_o_urg);
    assign o_entry_count = r_o_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CAP_N)
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("accepted word did not occupy the sequencer");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> o_entry_count == CAP_N)
        else $error("full status without a full heap");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_out_key == '0 && o_out_urgency == '0))
        else $error("failed operation returned an entry");

endmodule

`default_nettype wire

/* rtl/core/mhpq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Uses no package.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/mhpq_cmp.sv */
// Shared signed urgency comparator used by every sift step.
// Uses no package.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_cmp #(
    parameter int WIDTH = 16
) (
    input  wire logic signed [WIDTH-1:0] i_a,
    input  wire logic signed [WIDTH-1:0] i_b,
    output logic                         o_gt
);

    assign o_gt = (i_a > i_b);

endmodule

`default_nettype wire

/* test/max_heap_priority_queue_core_tb.sv */
// Self-checking testbench for the max-heap priority queue core.
// Random valid/stall traffic; a behavioral heap predicts every result word.
// Depends on mhpq_pkg and max_heap_priority_queue_core.
`timescale 1ns / 1ps

module max_heap_priority_queue_core_tb;

    import mhpq_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int KEY_W        = DEF_KEY_BITS;
    localparam int URG_W        = DEF_URGENCY_BITS;
    localparam int COUNT_W      = $clog2(CAPACITY + 1);
    localparam int RANDOM_WORDS = 1530;
    localparam int DRAIN_CYCLES = 200;
    localparam int PRINT_LIMIT  = 100;

    localparam t_op OP_UNUSED = 2'd3;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_CHURN = 2;
    localparam int MODE_MIXED = 3;

    typedef struct {
        t_op                      op;
        logic [KEY_W-1:0]         key;
        logic signed [URG_W-1:0]  urg;
    } t_word;

    typedef struct {
        t_status                  status;
        logic [KEY_W-1:0]         key;
        logic signed [URG_W-1:0]  urg;
        logic [COUNT_W-1:0]       count;
    } t_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    t_op                       i_op = OP_INSERT;
    logic [KEY_W-1:0]          i_key = '0;
    logic signed [URG_W-1:0]   i_urgency = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    t_status                   o_status;
    logic [KEY_W-1:0]          o_out_key;
    logic signed [URG_W-1:0]   o_out_urgency;
    logic [COUNT_W-1:0]        o_entry_count;

    max_heap_priority_queue_core #(
        .CAPACITY     (CAPACITY),
        .KEY_BITS     (KEY_W),
        .URGENCY_BITS (URG_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_urgency     (i_urgency),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_out_urgency (o_out_urgency),
        .o_entry_count (o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // behavioral heap, slots 1..CAPACITY
    logic [KEY_W-1:0]          pq_key [1:CAPACITY];
    logic signed [URG_W-1:0]   pq_urg [1:CAPACITY];
    int                        pq_fill = 0;

    t_word                     queued_words[$];
    t_result                   due_results[$];
    t_word                     on_bus;
    t_result                   head_result;
    int                        mismatches = 0;
    int                        results_seen = 0;
    int                        drv_gap = 0;
    bit                        drv_steady = 1'b0;
    int                        snk_hold = 0;
    bit                        snk_steady = 1'b0;

    function automatic void swap_slots(int a, int b);
        logic [KEY_W-1:0]         tk;
        logic signed [URG_W-1:0]  tu;
        tk = pq_key[a];
        tu = pq_urg[a];
        pq_key[a] = pq_key[b];
        pq_urg[a] = pq_urg[b];
        pq_key[b] = tk;
        pq_urg[b] = tu;
    endfunction

    function automatic int climb(int p);
        while (p > 1 && pq_urg[p / 2] < pq_urg[p]) begin
            swap_slots(p, p / 2);
            p = p / 2;
        end
        return p;
    endfunction

    function automatic int sink(int p);
        int l;
        int r;
        int c;
        forever begin
            l = 2 * p;
            r = l + 1;
            if (l > pq_fill)
                return p;
            c = (r <= pq_fill && !(pq_urg[l] > pq_urg[r])) ? r : l;
            if (pq_urg[c] > pq_urg[p]) begin
                swap_slots(c, p);
                p = c;
            end else begin
                return p;
            end
        end
    endfunction

    function automatic void take_out(int p);
        int last;
        last = pq_fill;
        if (p != last) begin
            pq_key[p] = pq_key[last];
            pq_urg[p] = pq_urg[last];
        end
        pq_fill = last - 1;
        if (p <= pq_fill) begin
            p = sink(p);
            void'(climb(p));
        end
    endfunction

    function automatic void serve_word(t_word w);
        t_result res;
        int      hit;
        int      p;
        res.status = ST_OK;
        res.key    = '0;
        res.urg    = '0;
        case (w.op)
            OP_INSERT: begin
                if (pq_fill >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    pq_fill++;
                    pq_key[pq_fill] = w.key;
                    pq_urg[pq_fill] = w.urg;
                    void'(climb(pq_fill));
                end
            end
            OP_POP: begin
                if (pq_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.key = pq_key[1];
                    res.urg = pq_urg[1];
                    take_out(1);
                end
            end
            OP_REMOVE: begin
                hit = 0;
                for (p = 1; p <= pq_fill; p++)
                    if (pq_key[p] == w.key)
                        hit = p;
                if (hit == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.key = pq_key[hit];
                    res.urg = pq_urg[hit];
                    take_out(hit);
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'(pq_fill);
        due_results.push_back(res);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(16, 60);
    endfunction

    function automatic void queue_word(t_op op, logic [KEY_W-1:0] key,
                                       logic signed [URG_W-1:0] urg);
        t_word w;
        w.op  = op;
        w.key = key;
        w.urg = urg;
        queued_words.push_back(w);
    endfunction

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch: %s", msg);
    endtask

    task automatic present();
        on_bus = queued_words.pop_front();
        i_valid   <= 1'b1;
        i_op      <= on_bus.op;
        i_key     <= on_bus.key;
        i_urgency <= on_bus.urg;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            drv_gap = 0;
        end else if (i_valid && !o_stall) begin
            serve_word(on_bus);
            if ($urandom_range(0, 63) == 0)
                drv_steady = !drv_steady;
            drv_gap = drv_steady ? 0 : pick_gap();
            if (drv_gap == 0 && queued_words.size() != 0)
                present();
            else
                i_valid <= 1'b0;
        end else if (!i_valid) begin
            if (drv_gap > 0)
                drv_gap--;
            else if (queued_words.size() != 0)
                present();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            snk_hold = 0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    report($sformatf("word %0d with nothing expected: status %0d key %0h",
                                     results_seen, o_status, o_out_key));
                end else begin
                    head_result = due_results.pop_front();
                    if (o_status !== head_result.status)
                        report($sformatf("word %0d status got %0d want %0d", results_seen,
                                         o_status, head_result.status));
                    if (o_out_key !== head_result.key)
                        report($sformatf("word %0d key got %0h want %0h", results_seen,
                                         o_out_key, head_result.key));
                    if (o_out_urgency !== head_result.urg)
                        report($sformatf("word %0d urgency got %0d want %0d", results_seen,
                                         o_out_urgency, head_result.urg));
                    if (o_entry_count !== head_result.count)
                        report($sformatf("word %0d count got %0d want %0d", results_seen,
                                         o_entry_count, head_result.count));
                end
            end
            if ($urandom_range(0, 255) == 0)
                snk_steady = !snk_steady;
            if (snk_hold > 0)
                snk_hold--;
            else if (!snk_steady && $urandom_range(0, 5) == 0)
                snk_hold = pick_gap();
            i_stall <= (snk_hold > 0);
        end
    end

    initial begin
        #15_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int                       mode;
        int                       len;
        int                       n;
        int                       r;
        t_op                      op;
        logic [KEY_W-1:0]         key;
        logic signed [URG_W-1:0]  urg;
        logic [KEY_W-1:0]         recent_keys[$];

        // empty heap, unused op, removal of the last slot
        queue_word(OP_POP, 16'h0000, 16'sh0000);
        queue_word(OP_REMOVE, 16'h0005, 16'sh0000);
        queue_word(OP_UNUSED, 16'h0000, 16'sh0000);
        queue_word(OP_INSERT, 16'h000a, 16'sd100);
        queue_word(OP_INSERT, 16'h000b, 16'sd50);
        queue_word(OP_REMOVE, 16'h000b, 16'sh0000);
        // field extremes, equal urgencies, duplicate keys
        queue_word(OP_INSERT, 16'hffff, 16'sh7fff);
        queue_word(OP_INSERT, 16'h0000, 16'sh8000);
        queue_word(OP_INSERT, 16'h0005, 16'sh0000);
        queue_word(OP_INSERT, 16'h0006, 16'sh0000);
        queue_word(OP_INSERT, 16'h0005, 16'sh7fff);
        queue_word(OP_REMOVE, 16'h0005, 16'shffff);
        queue_word(OP_REMOVE, 16'habcd, 16'sh0000);
        queue_word(OP_UNUSED, 16'hffff, 16'shffff);
        queue_word(OP_POP, 16'hffff, 16'shffff);
        repeat (5)
            queue_word(OP_POP, 16'h0000, 16'sh0000);
        // tie between children on the way down
        queue_word(OP_INSERT, 16'h0011, 16'sd100);
        queue_word(OP_INSERT, 16'h0012, 16'sd0);
        queue_word(OP_INSERT, 16'h0013, 16'sd0);
        queue_word(OP_INSERT, 16'h0014, -16'sd5);
        queue_word(OP_POP, 16'h0000, 16'sh0000);

        n = 0;
        mode = MODE_FILL;
        len = 90;
        while (n < RANDOM_WORDS) begin
            if (len > RANDOM_WORDS - n)
                len = RANDOM_WORDS - n;
            repeat (len) begin
                r = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL:  op = r < 85 ? OP_INSERT : r < 91 ? OP_REMOVE :
                                     r < 97 ? OP_POP : OP_UNUSED;
                    MODE_DRAIN: op = r < 78 ? OP_POP : r < 90 ? OP_REMOVE :
                                     r < 98 ? OP_INSERT : OP_UNUSED;
                    MODE_CHURN: op = r < 45 ? OP_REMOVE : r < 88 ? OP_INSERT :
                                     r < 98 ? OP_POP : OP_UNUSED;
                    default:    op = r < 40 ? OP_INSERT : r < 70 ? OP_POP :
                                     r < 95 ? OP_REMOVE : OP_UNUSED;
                endcase
                key = KEY_W'($urandom_range(0, 65535));
                urg = URG_W'($urandom_range(0, 65535));
                if (op == OP_INSERT) begin
                    if ($urandom_range(0, 2) != 0)
                        key = KEY_W'($urandom_range(0, 31));
                    r = $urandom_range(0, 99);
                    if (r < 40) begin
                        urg = URG_W'($urandom_range(0, 8));
                        urg = urg - 16'sd4;
                    end else if (r < 55) begin
                        case ($urandom_range(0, 3))
                            0: urg = 16'sh8000;
                            1: urg = 16'sh7fff;
                            2: urg = 16'shffff;
                            default: urg = 16'sh0000;
                        endcase
                    end
                    recent_keys.push_back(key);
                    if (recent_keys.size() > CAPACITY)
                        void'(recent_keys.pop_front());
                end else if (op == OP_REMOVE) begin
                    if (recent_keys.size() != 0 && $urandom_range(0, 4) != 0)
                        key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                    else if ($urandom_range(0, 1) != 0)
                        key = KEY_W'($urandom_range(0, 31));
                end
                queue_word(op, key, urg);
                n++;
            end
            mode = $urandom_range(MODE_FILL, MODE_MIXED);
            len = (mode == MODE_FILL) ? $urandom_range(30, 120) : $urandom_range(10, 80);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_words.size() != 0 || i_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_ram.sv
rtl/core/mhpq_cmp.sv
rtl/core/max_heap_priority_queue_core.sv
test/max_heap_priority_queue_core_tb.sv
